// File: rtl/core/ilp_pkg.sv
// shared types, constants and helper functions for the int8 projection tile
// no dependencies; imported by every module of the block
`default_nettype none

package ilp_pkg;

  // store geometry
  localparam int MAX_SEQUENCE    = 64;
  localparam int MAX_EMBEDDING   = 128;
  localparam int MAX_PROJECTIONS = 64;
  localparam int MAX_HEADS       = 4;

  localparam int LANES    = 4;                 // bytes per store word
  localparam int WORD_W   = 8 * LANES;
  localparam int IN_BYTES = MAX_SEQUENCE * MAX_EMBEDDING;
  localparam int W_BYTES  = MAX_HEADS * MAX_PROJECTIONS * MAX_EMBEDDING;
  localparam int IN_WORDS = IN_BYTES / LANES;
  localparam int W_WORDS  = W_BYTES / LANES;
  localparam int IN_AW    = $clog2(IN_WORDS);
  localparam int W_AW     = $clog2(W_WORDS);
  localparam int LANE_W   = $clog2(LANES);
  localparam int EW_W     = $clog2(MAX_EMBEDDING / LANES + 1);
  localparam int ACC_W    = 16 + $clog2(MAX_EMBEDDING) + 2;

  // field and register widths
  localparam int OP_W    = 2;
  localparam int ADDR_W  = 15;
  localparam int SEQ_W   = 7;
  localparam int EMB_W   = 8;
  localparam int PROJ_W  = 7;
  localparam int HEADS_W = 3;
  localparam int CIDX_W  = 2;
  localparam int CDATA_W = 8;

  // operation codes
  localparam logic [OP_W-1:0] OP_LOAD_INPUT  = 2'd0;
  localparam logic [OP_W-1:0] OP_LOAD_WEIGHT = 2'd1;
  localparam logic [OP_W-1:0] OP_COMPUTE     = 2'd2;

  // register indexes
  localparam logic [CIDX_W-1:0] CFG_SEQUENCE   = 2'd0;
  localparam logic [CIDX_W-1:0] CFG_EMBEDDING  = 2'd1;
  localparam logic [CIDX_W-1:0] CFG_PROJECTION = 2'd2;
  localparam logic [CIDX_W-1:0] CFG_HEADS      = 2'd3;

  // effective configuration after clamping and rounding
  typedef struct packed {
    logic [SEQ_W-1:0]   seq;
    logic [EW_W-1:0]    emb_w;   // embedding length in store words
    logic [PROJ_W-1:0]  proj;
    logic [HEADS_W-1:0] heads;
  } cfg_t;

  // sequencer to store and mac unit
  typedef struct packed {
    logic             rd;
    logic [IN_AW-1:0] in_addr0;
    logic [IN_AW-1:0] in_addr1;
    logic [W_AW-1:0]  w_addr0;
    logic [W_AW-1:0]  w_addr1;
    logic             mac_clear;
    logic             mac_en;
  } seq_ctl_t;

  // sequencer to result port
  typedef struct packed {
    logic       valid;
    logic [1:0] idx;
    logic [5:0] row;
    logic [5:0] col;
    logic       last;
  } emit_t;

  function automatic cfg_t cfg_clamp(input logic [SEQ_W-1:0] s, input logic [EMB_W-1:0] e,
                                     input logic [PROJ_W-1:0] p,
                                     input logic [HEADS_W-1:0] h);
    cfg_t               c;
    logic [SEQ_W-1:0]   sc;
    logic [EMB_W-1:0]   ec;
    logic [PROJ_W-1:0]  pc;
    logic [HEADS_W-1:0] hc;
    if (s < SEQ_W'(2)) sc = SEQ_W'(2);
    else if (int'(s) > MAX_SEQUENCE) sc = SEQ_W'(MAX_SEQUENCE);
    else sc = s;
    if (e < EMB_W'(4)) ec = EMB_W'(4);
    else if (int'(e) > MAX_EMBEDDING) ec = EMB_W'(MAX_EMBEDDING);
    else ec = e;
    if (p < PROJ_W'(2)) pc = PROJ_W'(2);
    else if (int'(p) > MAX_PROJECTIONS) pc = PROJ_W'(MAX_PROJECTIONS);
    else pc = p;
    if (h < HEADS_W'(1)) hc = HEADS_W'(1);
    else if (int'(h) > MAX_HEADS) hc = HEADS_W'(MAX_HEADS);
    else hc = h;
    c.seq   = {sc[SEQ_W-1:1], 1'b0};
    c.emb_w = EW_W'(ec >> LANE_W);
    c.proj  = {pc[PROJ_W-1:1], 1'b0};
    c.heads = hc;
    return c;
  endfunction

  function automatic logic signed [7:0] sat8(input logic signed [ACC_W-1:0] v);
    logic signed [7:0] r;
    if (v > 127) r = 8'sd127;
    else if (v < -128) r = -8'sd128;
    else r = v[7:0];
    return r;
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/ilp_store.sv
// input and weight byte stores, word organized with byte-lane writes
// two registered read ports per store; uses ilp_pkg
`default_nettype none

module ilp_store (
  input  wire logic                          clk,
  input  wire logic                          in_we,
  input  wire logic                          w_we,
  input  wire logic [ilp_pkg::ADDR_W-1:0]    wr_addr,
  input  wire logic [7:0]                    wr_data,
  input  wire ilp_pkg::seq_ctl_t             ctl,
  output logic      [1:0][ilp_pkg::WORD_W-1:0] x,
  output logic      [1:0][ilp_pkg::WORD_W-1:0] w
);
  import ilp_pkg::*;

  logic [WORD_W-1:0] in_mem [IN_WORDS];
  logic [WORD_W-1:0] w_mem  [W_WORDS];

  logic [LANE_W-1:0] lane;
  assign lane = wr_addr[LANE_W-1:0];

  always_ff @(posedge clk) begin
    if (in_we) begin
      in_mem[wr_addr[IN_AW+LANE_W-1:LANE_W]][lane*8 +: 8] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (w_we) begin
      w_mem[wr_addr[W_AW+LANE_W-1:LANE_W]][lane*8 +: 8] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.rd) begin
      x[0] <= in_mem[ctl.in_addr0];
      x[1] <= in_mem[ctl.in_addr1];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.rd) begin
      w[0] <= w_mem[ctl.w_addr0];
      w[1] <= w_mem[ctl.w_addr1];
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/ilp_mac.sv
// shared four-lane multiply-accumulate unit for the 2x2 tile
// one store word per row and column each cycle; uses ilp_pkg
`default_nettype none

module ilp_mac (
  input  wire logic                             clk,
  input  wire ilp_pkg::seq_ctl_t                ctl,
  input  wire logic [1:0][ilp_pkg::WORD_W-1:0]  x,
  input  wire logic [1:0][ilp_pkg::WORD_W-1:0]  w,
  output logic      [3:0][ilp_pkg::ACC_W-1:0]   acc
);
  import ilp_pkg::*;

  logic signed [15:0]      prod [4][LANES];
  logic signed [ACC_W-1:0] sum  [4];

  // accumulator k pairs row k/2 with column k%2
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      sum[k] = '0;
      for (int l = 0; l < LANES; l++) begin
        prod[k][l] = $signed(x[k/2][l*8 +: 8]) * $signed(w[k%2][l*8 +: 8]);
        sum[k]     = sum[k] + ACC_W'(prod[k][l]);
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 4; k++) begin
      if (ctl.mac_clear) begin
        acc[k] <= '0;
      end else if (ctl.mac_en) begin
        acc[k] <= ACC_W'($signed(acc[k]) + sum[k]);
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/ilp_seq.sv
// tile sequencer: bounds check, base address setup, embedding walk, result emit
// drives the store read ports and the mac unit; uses ilp_pkg
`default_nettype none

module ilp_seq (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 item_valid,
  input  wire logic [1:0]           op,
  input  wire logic [1:0]           head_select,
  input  wire logic [4:0]           row_pair,
  input  wire logic [4:0]           column_pair,
  input  wire ilp_pkg::cfg_t        cfg,
  input  wire logic                 result_stall,
  output logic                      item_stall,
  output ilp_pkg::seq_ctl_t         ctl,
  output ilp_pkg::emit_t            emit
);
  import ilp_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SETUP = 3'd1;
  localparam logic [2:0] S_BASE  = 3'd2;
  localparam logic [2:0] S_WALK  = 3'd3;
  localparam logic [2:0] S_DRAIN = 3'd4;
  localparam logic [2:0] S_EMIT  = 3'd5;

  logic [2:0]       state;
  logic             rd_q;
  logic [1:0]       idx;
  logic [1:0]       head;
  logic [5:0]       r0;
  logic [5:0]       c0;
  logic [EW_W-1:0]  cnt;
  logic [IN_AW-1:0] a0;
  logic [W_AW-1:0]  cb;
  logic [W_AW-1:0]  hp;
  logic [W_AW-1:0]  b0;

  logic            tile_ok;
  logic            start;
  logic [EW_W-1:0] ew_last;

  assign tile_ok = ({1'b0, head_select} < cfg.heads) &&
                   ({1'b0, row_pair, 1'b0} + SEQ_W'(1) < cfg.seq) &&
                   ({1'b0, column_pair, 1'b0} + PROJ_W'(1) < cfg.proj);
  assign start   = (state == S_IDLE) && item_valid && (op == OP_COMPUTE) && tile_ok;
  assign ew_last = cfg.emb_w - EW_W'(1);

  assign item_stall = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      rd_q  <= 1'b0;
      idx   <= 2'd0;
    end else begin
      rd_q <= (state == S_WALK);
      case (state)
        S_IDLE:  if (start) state <= S_SETUP;
        S_SETUP: state <= S_BASE;
        S_BASE:  state <= S_WALK;
        S_WALK:  if (cnt == ew_last) state <= S_DRAIN;
        S_DRAIN: state <= S_EMIT;
        S_EMIT: begin
          if (!result_stall) begin
            idx <= idx + 2'd1;
            if (idx == 2'd3) state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // address setup runs one small multiply per register
  always_ff @(posedge clk) begin
    if (start) begin
      head <= head_select;
      r0   <= {row_pair, 1'b0};
      c0   <= {column_pair, 1'b0};
    end
    if (state == S_SETUP) begin
      a0 <= IN_AW'(r0) * IN_AW'(cfg.emb_w);
      cb <= W_AW'(c0) * W_AW'(cfg.emb_w);
      hp <= W_AW'(cfg.emb_w) * W_AW'(cfg.proj);
    end
    if (state == S_BASE) begin
      b0  <= W_AW'(head) * hp + cb;
      cnt <= '0;
    end
    if (state == S_WALK) begin
      cnt <= cnt + EW_W'(1);
    end
  end

  always_comb begin
    ctl.rd        = (state == S_WALK);
    ctl.in_addr0  = a0 + IN_AW'(cnt);
    ctl.in_addr1  = a0 + IN_AW'(cfg.emb_w) + IN_AW'(cnt);
    ctl.w_addr0   = b0 + W_AW'(cnt);
    ctl.w_addr1   = b0 + W_AW'(cfg.emb_w) + W_AW'(cnt);
    ctl.mac_clear = (state == S_BASE);
    ctl.mac_en    = rd_q;
  end

  always_comb begin
    emit.valid = (state == S_EMIT);
    emit.idx   = idx;
    emit.row   = r0 + {5'b0, idx[1]};
    emit.col   = c0 + {5'b0, idx[0]};
    emit.last  = (idx == 2'd3);
  end

endmodule

`default_nettype wire

// File: rtl/core/int8_linear_projection_tile.sv
// top level of the int8 2x2 projection tile: config registers, store writes, result port
// depends on ilp_pkg, ilp_store, ilp_mac, ilp_seq
`default_nettype none

//  channel  | handshake               | payload
//  ---------+-------------------------+---------------------------------------------------
//  item     | item_valid / item_stall | op, load_address, load_value, head_select,
//           |                         | row_pair, column_pair
//  result   | result_valid /          | result_value, result_row, result_column, tile_last
//           | result_stall            |
//  config   | cfg_valid / cfg_ready   | cfg_index, cfg_data
//
//  a compute tile walks the embedding at one 32-bit word per row and column per cycle
//  from the two read ports of each store; the four-lane mac adds the words up.
//  reset sets the config registers to their maxima and clears control, not the stores.
//  item_stall is high from an in-bounds compute transfer until its fourth result transfer;
//  result_stall holds the current result on the port.

module int8_linear_projection_tile (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          item_valid,
  output logic                               item_stall,
  input  wire logic [ilp_pkg::OP_W-1:0]      op,
  input  wire logic [ilp_pkg::ADDR_W-1:0]    load_address,
  input  wire logic signed [7:0]             load_value,
  input  wire logic [1:0]                    head_select,
  input  wire logic [4:0]                    row_pair,
  input  wire logic [4:0]                    column_pair,
  output logic                               result_valid,
  input  wire logic                          result_stall,
  output logic signed [7:0]                  result_value,
  output logic      [5:0]                    result_row,
  output logic      [5:0]                    result_column,
  output logic                               tile_last,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [ilp_pkg::CIDX_W-1:0]    cfg_index,
  input  wire logic [ilp_pkg::CDATA_W-1:0]   cfg_data
);
  import ilp_pkg::*;

  logic [SEQ_W-1:0]   raw_seq;
  logic [EMB_W-1:0]   raw_emb;
  logic [PROJ_W-1:0]  raw_proj;
  logic [HEADS_W-1:0] raw_heads;
  cfg_t               cfg;

  logic                   accept;
  logic                   in_we;
  logic                   w_we;
  seq_ctl_t               ctl;
  emit_t                  emit;
  logic [1:0][WORD_W-1:0] x;
  logic [1:0][WORD_W-1:0] w;
  logic [3:0][ACC_W-1:0]  acc;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      raw_seq   <= SEQ_W'(MAX_SEQUENCE);
      raw_emb   <= EMB_W'(MAX_EMBEDDING);
      raw_proj  <= PROJ_W'(MAX_PROJECTIONS);
      raw_heads <= HEADS_W'(MAX_HEADS);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_SEQUENCE:   raw_seq   <= cfg_data[SEQ_W-1:0];
        CFG_EMBEDDING:  raw_emb   <= cfg_data[EMB_W-1:0];
        CFG_PROJECTION: raw_proj  <= cfg_data[PROJ_W-1:0];
        CFG_HEADS:      raw_heads <= cfg_data[HEADS_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_clamp(raw_seq, raw_emb, raw_proj, raw_heads);

  // loads past the store depth are dropped
  assign accept = item_valid && !item_stall;
  assign in_we  = accept && (op == OP_LOAD_INPUT) && (int'(load_address) < IN_BYTES);
  assign w_we   = accept && (op == OP_LOAD_WEIGHT) && (int'(load_address) < W_BYTES);

  ilp_store u_store (
    .clk     (clk),
    .in_we   (in_we),
    .w_we    (w_we),
    .wr_addr (load_address),
    .wr_data (load_value),
    .ctl     (ctl),
    .x       (x),
    .w       (w)
  );

  ilp_mac u_mac (
    .clk (clk),
    .ctl (ctl),
    .x   (x),
    .w   (w),
    .acc (acc)
  );

  ilp_seq u_seq (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .op           (op),
    .head_select  (head_select),
    .row_pair     (row_pair),
    .column_pair  (column_pair),
    .cfg          (cfg),
    .result_stall (result_stall),
    .item_stall   (item_stall),
    .ctl          (ctl),
    .emit         (emit)
  );

  assign result_valid  = emit.valid;
  assign result_value  = sat8(acc[emit.idx]);
  assign result_row    = emit.row;
  assign result_column = emit.col;
  assign tile_last     = emit.last;

endmodule

`default_nettype wire

// File: tb/ilp_tile_checker.sv
// result checker for the int8 2x2 projection tile: keeps its own copy of both byte
// stores and of the shape registers, predicts every tile and compares each transfer
// depends on ilp_pkg for widths, op codes and register indexes
`timescale 1ns / 1ps

module ilp_tile_checker
  import ilp_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  input  logic                item_stall,
  input  logic [OP_W-1:0]     op,
  input  logic [ADDR_W-1:0]   load_address,
  input  logic signed [7:0]   load_value,
  input  logic [1:0]          head_select,
  input  logic [4:0]          row_pair,
  input  logic [4:0]          column_pair,
  input  logic                result_valid,
  input  logic                result_stall,
  input  logic signed [7:0]   result_value,
  input  logic [5:0]          result_row,
  input  logic [5:0]          result_column,
  input  logic                tile_last,
  input  logic                cfg_valid,
  input  logic                cfg_ready,
  input  logic [CIDX_W-1:0]   cfg_index,
  input  logic [CDATA_W-1:0]  cfg_data,
  output int                  mismatches,
  output int                  outputs_due,
  output int                  seq_now,
  output int                  emb_now,
  output int                  proj_now,
  output int                  heads_now
);

  typedef struct packed {
    logic signed [7:0] value;
    logic [5:0]        row;
    logic [5:0]        col;
    logic              last;
  } tile_output_t;

  logic signed [7:0] input_bytes  [IN_BYTES];
  logic signed [7:0] weight_bytes [W_BYTES];
  tile_output_t      tile_outputs [$];
  tile_output_t      want;

  int seq_reg, emb_reg, proj_reg, heads_reg;
  int seq_eff, emb_eff, proj_eff, heads_eff;
  int r0, c0, a0, b0, k;

  initial mismatches = 0;

  function automatic int clamp_to(input int v, input int lo, input int hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic int dot_bytes(input int ia, input int wa, input int n);
    int acc;
    acc = 0;
    for (int e = 0; e < n; e++) acc += int'(input_bytes[ia + e]) * int'(weight_bytes[wa + e]);
    return acc;
  endfunction

  function automatic logic signed [7:0] clip8(input int v);
    if (v > 127) return 8'sd127;
    if (v < -128) return -8'sd128;
    return 8'(v);
  endfunction

  task automatic report_mismatch(input string text);
    mismatches++;
    if (mismatches <= 100) $display("[%0t] mismatch: %s", $realtime, text);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      seq_reg   = MAX_SEQUENCE;
      emb_reg   = MAX_EMBEDDING;
      proj_reg  = MAX_PROJECTIONS;
      heads_reg = MAX_HEADS;
      tile_outputs.delete();
    end else begin
      // retire before predicting so a same-edge compute never matches an older result
      if (result_valid && !result_stall) begin
        if (tile_outputs.size() == 0) begin
          report_mismatch($sformatf("result (%0d,%0d) value %0d with nothing due",
                                    result_row, result_column, result_value));
        end else begin
          want = tile_outputs.pop_front();
          if (result_value !== want.value)
            report_mismatch($sformatf("value at (%0d,%0d): got %0d, expected %0d",
                                      want.row, want.col, result_value, want.value));
          if (result_row !== want.row)
            report_mismatch($sformatf("row: got %0d, expected %0d", result_row, want.row));
          if (result_column !== want.col)
            report_mismatch($sformatf("column: got %0d, expected %0d",
                                      result_column, want.col));
          if (tile_last !== want.last)
            report_mismatch($sformatf("tile_last at (%0d,%0d): got %0b, expected %0b",
                                      want.row, want.col, tile_last, want.last));
        end
      end

      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_SEQUENCE:   seq_reg   = int'(cfg_data[SEQ_W-1:0]);
          CFG_EMBEDDING:  emb_reg   = int'(cfg_data[EMB_W-1:0]);
          CFG_PROJECTION: proj_reg  = int'(cfg_data[PROJ_W-1:0]);
          CFG_HEADS:      heads_reg = int'(cfg_data[HEADS_W-1:0]);
          default: ;
        endcase
      end

      // shape in use: clamped, then rounded down to the required multiple
      seq_eff   = clamp_to(seq_reg, 2, MAX_SEQUENCE) & ~1;
      emb_eff   = clamp_to(emb_reg, 4, MAX_EMBEDDING) & ~3;
      proj_eff  = clamp_to(proj_reg, 2, MAX_PROJECTIONS) & ~1;
      heads_eff = clamp_to(heads_reg, 1, MAX_HEADS);

      if (item_valid && !item_stall) begin
        case (op)
          OP_LOAD_INPUT:  if (int'(load_address) < IN_BYTES) input_bytes[load_address] = load_value;
          OP_LOAD_WEIGHT: if (int'(load_address) < W_BYTES) weight_bytes[load_address] = load_value;
          OP_COMPUTE: begin
            r0 = 2 * int'(row_pair);
            c0 = 2 * int'(column_pair);
            if (int'(head_select) < heads_eff && r0 + 1 < seq_eff && c0 + 1 < proj_eff) begin
              a0 = r0 * emb_eff;
              b0 = int'(head_select) * emb_eff * proj_eff + c0 * emb_eff;
              for (k = 0; k < 4; k++) begin
                want.value = clip8(dot_bytes(a0 + (k >> 1) * emb_eff, b0 + (k & 1) * emb_eff,
                                             emb_eff));
                want.row   = 6'(r0 + (k >> 1));
                want.col   = 6'(c0 + (k & 1));
                want.last  = (k == 3);
                tile_outputs.push_back(want);
              end
            end
          end
          default: ;  // unused op code does nothing
        endcase
      end
    end

    outputs_due <= tile_outputs.size();
    seq_now     <= clamp_to(seq_reg, 2, MAX_SEQUENCE) & ~1;
    emb_now     <= clamp_to(emb_reg, 4, MAX_EMBEDDING) & ~3;
    proj_now    <= clamp_to(proj_reg, 2, MAX_PROJECTIONS) & ~1;
    heads_now   <= clamp_to(heads_reg, 1, MAX_HEADS);
  end

endmodule

// File: tb/tb_int8_linear_projection_tile.sv
// top of the int8 2x2 projection tile testbench: clock, reset, shape register writes,
// load and compute stimulus with bursty traffic and random result stalls, final verdict
// depends on ilp_pkg, int8_linear_projection_tile and ilp_tile_checker
`timescale 1ns / 1ps

module tb_int8_linear_projection_tile;
  import ilp_pkg::*;

  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int SETTLE     = 48;
  localparam int LONG_HOLD  = 300;
  localparam int IDLE_LIMIT = 2000;
  localparam int PHASES     = 6;
  localparam logic [CIDX_W-1:0] REG_ORDER [4] =
    '{CFG_SEQUENCE, CFG_EMBEDDING, CFG_PROJECTION, CFG_HEADS};

  // raw register writes per phase: sequence, embedding, projections, heads
  // several are out of range or odd on purpose to hit clamping and rounding
  int shape_table [PHASES][4] = '{
    '{64, 4, 64, 4},
    '{2, 8, 2, 1},
    '{0, 6, 0, 0},
    '{7, 10, 5, 3},
    '{200, 12, 127, 7},
    '{1, 3, 1, 2}
  };
  int phase_items [PHASES] = '{90, 45, 15, 85, 100, 65};

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     item_valid = 1'b0;
  logic                     item_stall;
  logic [OP_W-1:0]          op = OP_LOAD_INPUT;
  logic [ADDR_W-1:0]        load_address = '0;
  logic signed [7:0]        load_value = '0;
  logic [1:0]               head_select = '0;
  logic [4:0]               row_pair = '0;
  logic [4:0]               column_pair = '0;
  logic                     result_valid;
  logic                     result_stall = 1'b0;
  logic signed [7:0]        result_value;
  logic [5:0]               result_row;
  logic [5:0]               result_column;
  logic                     tile_last;
  logic                     cfg_valid = 1'b0;
  logic                     cfg_ready;
  logic [CIDX_W-1:0]        cfg_index = CFG_SEQUENCE;
  logic [CDATA_W-1:0]       cfg_data = '0;

  int  mismatches, outputs_due, seq_now, emb_now, proj_now, heads_now;
  bit  input_seen  [IN_BYTES];
  bit  weight_seen [W_BYTES];
  int  items_sent = 0;
  int  burst_left = 0;
  logic hold_request = 1'b0;
  bit  hold_served = 1'b0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  int8_linear_projection_tile dut (
    .clk, .rst, .item_valid, .item_stall, .op, .load_address, .load_value, .head_select,
    .row_pair, .column_pair, .result_valid, .result_stall, .result_value, .result_row,
    .result_column, .tile_last, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  ilp_tile_checker u_checker (
    .clk, .rst, .item_valid, .item_stall, .op, .load_address, .load_value, .head_select,
    .row_pair, .column_pair, .result_valid, .result_stall, .result_value, .result_row,
    .result_column, .tile_last, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
    .mismatches, .outputs_due, .seq_now, .emb_now, .proj_now, .heads_now
  );

  // one item transfer; the sender runs in bursts with random gaps between them
  task automatic push_item(input logic [OP_W-1:0] o, input logic [ADDR_W-1:0] a,
                           input logic signed [7:0] v, input logic [1:0] h,
                           input logic [4:0] rp, input logic [4:0] cp);
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 12);
      gap = $urandom_range(0, 7);
      if (gap > 0) begin
        item_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    item_valid   <= 1'b1;
    op           <= o;
    load_address <= a;
    load_value   <= v;
    head_select  <= h;
    row_pair     <= rp;
    column_pair  <= cp;
    do @(posedge clk); while (item_stall);
    items_sent++;
  endtask

  task automatic load_byte(input logic [OP_W-1:0] o, input int a, input logic signed [7:0] v);
    if (o == OP_LOAD_INPUT && a < IN_BYTES) input_seen[a] = 1'b1;
    if (o == OP_LOAD_WEIGHT && a < W_BYTES) weight_seen[a] = 1'b1;
    push_item(o, ADDR_W'(a), v, 2'($urandom), 5'($urandom), 5'($urandom));
  endtask

  function automatic logic signed [7:0] fill_value(input int mode);
    case (mode)
      0: return 8'($urandom);
      3: return $urandom_range(0, 1) ? 8'sd127 : -8'sd128;
      default: return 8'($urandom_range(0, 6) - 3);  // small values keep sums unsaturated
    endcase
  endfunction

  // loads the bytes the tile still lacks (at short embeddings sometimes all), then requests
  // it; a tile out of bounds loads nothing and goes straight to the compute request
  task automatic run_tile(input logic [1:0] h, input logic [4:0] rp, input logic [4:0] cp,
                          input int mode);
    int  e_len, a;
    bit  refresh;
    if (int'(h) < heads_now && 2 * int'(rp) + 1 < seq_now && 2 * int'(cp) + 1 < proj_now) begin
      e_len = emb_now;
      refresh = (e_len <= 16) && ($urandom_range(0, 3) == 0);
      for (int k = 0; k < 2; k++) begin
        for (int e = 0; e < e_len; e++) begin
          a = (2 * int'(rp) + k) * e_len + e;
          if (refresh || !input_seen[a]) load_byte(OP_LOAD_INPUT, a, fill_value(mode));
          a = int'(h) * e_len * proj_now + (2 * int'(cp) + k) * e_len + e;
          if (refresh || !weight_seen[a]) load_byte(OP_LOAD_WEIGHT, a, fill_value(mode));
        end
      end
    end
    push_item(OP_COMPUTE, ADDR_W'($urandom), 8'($urandom), h, rp, cp);
  endtask

  task automatic drain_outputs();
    item_valid <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (outputs_due != 0);
  endtask

  task automatic write_shape(input int p);
    drain_outputs();
    repeat (SETTLE) @(posedge clk);
    for (int i = 0; i < 4; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= REG_ORDER[i];
      cfg_data  <= CDATA_W'(shape_table[p][i]);
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_valid <= 1'b0;
    @(posedge clk);  // let the new shape show up on the checker outputs
  endtask

  // result side: segments of free flow, light and heavy random stalls, a fixed
  // pattern, plus one long hold-off so the tile backs up into the item channel
  initial begin : result_side
    int mode, span, hold_left, tick;
    hold_left = 0;
    tick = 0;
    wait (!rst);
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(20, 150);
      repeat (span) begin
        if (hold_request && !hold_served) begin
          hold_served = 1'b1;
          hold_left = LONG_HOLD;
        end
        tick++;
        if (hold_left > 0) begin
          result_stall <= 1'b1;
          hold_left--;
        end else begin
          case (mode)
            0: result_stall <= 1'b0;
            1: result_stall <= ($urandom_range(0, 3) == 0);
            2: result_stall <= ($urandom_range(0, 3) != 0);
            default: result_stall <= (tick % 5 < 2);
          endcase
        end
        @(posedge clk);
      end
    end
  end

  initial begin : watchdog
    int idle_run;
    idle_run = 0;
    while (idle_run < IDLE_LIMIT) begin
      @(posedge clk);
      if (rst || (item_valid && !item_stall) || (result_valid && !result_stall) ||
          (cfg_valid && cfg_ready))
        idle_run = 0;
      else
        idle_run++;
    end
    $display("int8_linear_projection_tile regression: fail");
    $finish;
  end

  initial begin : stimulus
    int start, choice, steps;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int p = 0; p < PHASES; p++) begin
      write_shape(p);

      if (p == 0) begin
        // last row pair, last column pair, last head at embedding 4: all 127 saturates
        // high, then weights of -128 saturate low
        for (int a = 248; a < 256; a++) load_byte(OP_LOAD_INPUT, a, 8'sd127);
        for (int a = 1016; a < 1024; a++) load_byte(OP_LOAD_WEIGHT, a, 8'sd127);
        push_item(OP_COMPUTE, '1, 8'sd0, 2'd3, 5'd31, 5'd31);
        for (int a = 1016; a < 1024; a++) load_byte(OP_LOAD_WEIGHT, a, -8'sd128);
        push_item(OP_COMPUTE, '0, -8'sd1, 2'd3, 5'd31, 5'd31);
        // input load past the store is dropped, weight load at the top address is kept
        load_byte(OP_LOAD_INPUT, 32767, -8'sd128);
        load_byte(OP_LOAD_WEIGHT, 32767, 8'sd127);
        push_item(OP_UNUSED, '1, -8'sd1, 2'd3, 5'd31, 5'd31);
        hold_request <= 1'b1;
      end

      start = items_sent;
      steps = 0;
      while (items_sent - start < phase_items[p]) begin
        choice = (steps == 0) ? 0 : $urandom_range(0, 99);
        if (choice < 60)
          run_tile(2'($urandom_range(0, heads_now - 1)), 5'($urandom_range(0, seq_now / 2 - 1)),
                   5'($urandom_range(0, proj_now / 2 - 1)), $urandom_range(0, 3));
        else if (choice < 75)
          load_byte($urandom_range(0, 1) ? OP_LOAD_WEIGHT : OP_LOAD_INPUT,
                    $urandom_range(0, 32767), 8'($urandom));
        else if (choice < 85)
          run_tile(2'($urandom), 5'($urandom), 5'($urandom), $urandom_range(0, 3));
        else if (choice < 93)
          push_item(OP_UNUSED, ADDR_W'($urandom), 8'($urandom), 2'($urandom), 5'($urandom),
                    5'($urandom));
        else
          drain_outputs();
        steps++;
      end
    end

    drain_outputs();
    repeat (SETTLE) @(posedge clk);
    if (mismatches == 0)
      $display("int8_linear_projection_tile regression: pass");
    else
      $display("int8_linear_projection_tile regression: fail");
    $finish;
  end

endmodule

// File: int8_linear_projection_tile.f
rtl/core/ilp_pkg.sv
rtl/core/ilp_store.sv
rtl/core/ilp_mac.sv
rtl/core/ilp_seq.sv
rtl/core/int8_linear_projection_tile.sv
tb/ilp_tile_checker.sv
tb/tb_int8_linear_projection_tile.sv
